// ===== src/bvs_pkg.sv =====
`default_nettype none

package bvs_pkg;

  // configuration register layout
  localparam int unsigned RegWidth  = 10;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned BusWidth  = 32;

  localparam logic [RegWidth-1:0] DeadBandRst = 10'd5;
  localparam logic [RegWidth-1:0] SnapRst     = 10'd30;
  localparam logic [RegWidth-1:0] HoldRst     = 10'd400;

  typedef enum logic [1:0] {
    RegDeadBand = 2'd0,
    RegSnap     = 2'd1,
    RegHold     = 2'd2
  } bvs_reg_e;

  typedef struct packed {
    logic [RegWidth-1:0] dead_band;
    logic [RegWidth-1:0] snap_threshold;
    logic [RegWidth-1:0] hold_count;
  } bvs_cfg_t;

  // control state of the smoother that does not depend on the sample width
  typedef struct packed {
    logic                primed;
    logic                below;
    logic [RegWidth-1:0] hold_timer;
  } bvs_ctl_t;

endpackage

`default_nettype wire

// ===== src/bvs_regs.sv =====
`default_nettype none

module bvs_regs
  import bvs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel_i,
  input  wire logic                 penable_i,
  input  wire logic                 pwrite_i,
  input  wire logic [AddrWidth-1:0] paddr_i,
  input  wire logic [BusWidth-1:0]  pwdata_i,
  output logic      [BusWidth-1:0]  prdata_o,
  output logic                      pready_o,
  output bvs_cfg_t                  cfg_o
);

  bvs_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  bvs_reg_e sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign sel      = bvs_reg_e'(paddr_i[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        RegDeadBand: cfg_d.dead_band      = pwdata_i[RegWidth-1:0];
        RegSnap:     cfg_d.snap_threshold = pwdata_i[RegWidth-1:0];
        RegHold:     cfg_d.hold_count     = pwdata_i[RegWidth-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      RegDeadBand: prdata_o = BusWidth'(cfg_q.dead_band);
      RegSnap:     prdata_o = BusWidth'(cfg_q.snap_threshold);
      RegHold:     prdata_o = BusWidth'(cfg_q.hold_count);
      default:     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band      <= DeadBandRst;
      cfg_q.snap_threshold <= SnapRst;
      cfg_q.hold_count     <= HoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/bvs_step.sv =====
`default_nettype none

module bvs_step
  import bvs_pkg::*;
#(
  parameter int unsigned VOLT_WIDTH = 10
) (
  input  wire logic [VOLT_WIDTH-1:0] volt_i,
  input  wire logic [VOLT_WIDTH-1:0] filter_i,
  input  wire bvs_ctl_t              ctl_i,
  input  wire bvs_cfg_t              cfg_i,
  output logic      [VOLT_WIDTH-1:0] filter_o,
  output bvs_ctl_t                   ctl_o
);

  localparam int unsigned W  = VOLT_WIDTH;
  localparam int unsigned XW = W + 5;   // holds 24 * (2^W - 1)
  localparam int unsigned YW = W + 2;   // sum after dropping the divide-by-8 bits
  localparam int unsigned K  = W + 3;   // reciprocal shift, exact for YW-bit values
  localparam int unsigned PW = YW + K;
  localparam int unsigned CW = (W > RegWidth) ? W : RegWidth;
  localparam logic [K-1:0] RecipThird = K'(((2 ** K) + 2) / 3);

  logic        [XW-1:0] vx, fx, sum;
  logic        [YW-1:0] sum_div8;
  logic        [PW-1:0] prod;
  logic        [YW-1:0] quot;
  logic        [W-1:0]  avg, f1, f2, mag;
  logic signed [W:0]    diff;
  logic                 below;
  logic        [CW-1:0] mag_c, dead_c, snap_c, timer_c, hold_c;
  logic [RegWidth-1:0]  timer1;
  logic signed [W+1:0]  corr;

  always_comb begin
    // (v + 23 f) / 24 as ((v + 24 f - f) >> 3) / 3
    vx       = XW'(volt_i);
    fx       = XW'(filter_i);
    sum      = vx + (fx << 4) + (fx << 3) - fx;
    sum_div8 = sum[XW-1:3];
    prod     = PW'(sum_div8) * PW'(RecipThird);
    quot     = prod[PW-1:K];
    avg      = quot[W-1:0];
    f1       = ctl_i.primed ? avg : volt_i;

    diff  = $signed({1'b0, volt_i}) - $signed({1'b0, f1});
    below = diff[W] | (diff == '0);
    mag   = diff[W] ? W'(-diff) : W'(diff);

    mag_c  = CW'(mag);
    dead_c = CW'(cfg_i.dead_band);
    snap_c = CW'(cfg_i.snap_threshold);
    hold_c = CW'(cfg_i.hold_count);

    timer1 = (below != ctl_i.below) ? '0 : ctl_i.hold_timer;
    f2     = f1;
    if (mag_c < dead_c) begin
      timer1 = '0;
    end else if (mag_c > snap_c) begin
      timer1 = '0;
      f2     = volt_i;
    end

    timer_c      = CW'(timer1);
    corr         = $signed({2'b00, f2}) + $signed({diff[W], diff});
    ctl_o.primed = 1'b1;
    ctl_o.below  = below;
    if (timer_c < hold_c) begin
      ctl_o.hold_timer = timer1 + RegWidth'(1);
      filter_o         = f2;
    end else begin
      ctl_o.hold_timer = '0;
      // saturate the correction to the sample range
      if (corr[W+1]) begin
        filter_o = '0;
      end else if (corr[W]) begin
        filter_o = '1;
      end else begin
        filter_o = corr[W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/battery_voltage_smoother_unit.sv =====
`default_nettype none

// channel   | direction | payload
// s_axis    | in        | tdata: bat_voltage
// m_axis    | out       | tdata: filtered_voltage
// apb       | in        | dead_band @0x0, snap_threshold @0x4, hold_count @0x8
//
// one sample per cycle sustained while m_axis is ready; a result passes the input register,
// then the update logic and the result register, one result per sample
// reset clears the filter, the primed flag and the hold timer and loads register defaults
// a stalled result holds in the result register while the input register still takes
// one more sample; the input side stalls only when both are full

module battery_voltage_smoother_unit
  import bvs_pkg::*;
#(
  parameter int unsigned VOLT_WIDTH = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [VOLT_WIDTH-1:0] bat_voltage
  input  wire logic [((VOLT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [VOLT_WIDTH-1:0] filtered_voltage
  output logic      [((VOLT_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic [AddrWidth-1:0]            paddr_i,
  input  wire logic [BusWidth-1:0]             pwdata_i,
  output logic      [BusWidth-1:0]             prdata_o,
  output logic                                 pready_o
);

  localparam int unsigned W  = VOLT_WIDTH;
  localparam int unsigned DW = ((VOLT_WIDTH + 7) / 8) * 8;

  bvs_cfg_t cfg;

  logic         in_vld_q, in_vld_d;
  logic [W-1:0] in_data_q;
  logic         out_vld_q, out_vld_d;
  logic [W-1:0] out_data_q;
  logic [W-1:0] filter_q, filter_nxt;
  bvs_ctl_t     ctl_q, ctl_nxt;
  logic         s_xfer, advance;

  bvs_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  bvs_step #(
    .VOLT_WIDTH (VOLT_WIDTH)
  ) u_step (
    .volt_i   (in_data_q),
    .filter_i (filter_q),
    .ctl_i    (ctl_q),
    .cfg_i    (cfg),
    .filter_o (filter_nxt),
    .ctl_o    (ctl_nxt)
  );

  assign advance         = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | advance;
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q         <= 1'b0;
      out_vld_q        <= 1'b0;
      filter_q         <= '0;
      ctl_q.primed     <= 1'b0;
      ctl_q.below      <= 1'b1;
      ctl_q.hold_timer <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        filter_q <= filter_nxt;
        ctl_q    <= ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_data_q <= s_axis_tdata_i[W-1:0];
    end
    if (advance) begin
      out_data_q <= filter_nxt;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = DW'(out_data_q);

endmodule

`default_nettype wire
